/* design/assert_macros.svh */
// Assertion macros shared by the text console writer RTL.
// Concurrent checks on a clock with a synchronous active-high reset; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* design/tcw_pkg.sv */
// Package for the text console writer: field widths, codes, cell constants and bundles.
// No dependencies; imported by every module of the block.
package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // field widths
  localparam int LOC_W      = 11;
  localparam int CELL_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 32;

  // item kinds
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // character and cell codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CELL_W-1:0] BLANK_FILL   = 16'h0020;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  // one input item
  typedef struct packed {
    logic [LOC_W-1:0]  cell_address;
    logic [CHAR_W-1:0] character;
    logic              mode;
  } cmd_t;

  // one result item, packed as it leaves on the output stream
  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
    logic [LOC_W-1:0]  cursor_location;
  } res_t;

endpackage

/* design/tcw_screen_ram.sv */
// Screen cell store: one write port, one read port with registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
  parameter int AW    = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/tcw_ctrl.sv */
// Sequencer of the text console writer: cursor, clearing pass, scroll copy and the
// shared cell address unit that drives the screen store. Depends on tcw_pkg and assert macros.
`include "assert_macros.svh"
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int  COLUMNS = COLUMNS_DEF,
  parameter int  ROWS    = ROWS_DEF,
  localparam int CELLS   = COLUMNS * ROWS,
  localparam int AW      = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  input  logic [ATTR_W-1:0] attr,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [CELL_W-1:0] wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [CELL_W-1:0] rd_data
);

  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLUMNS);
  localparam int CMPW = ((AW > LOC_W) ? AW : LOC_W) + 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  localparam logic [AW-1:0]   LAST_CELL     = AW'(CELLS - 1);
  localparam logic [AW-1:0]   LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0]   COL_STEP      = AW'(COLUMNS);
  localparam logic [AW:0]     CELLS_X       = (AW + 1)'(CELLS);
  localparam logic [CMPW-1:0] CELLS_C       = CMPW'(CELLS);
  localparam logic [RW-1:0]   LAST_ROW      = RW'(ROWS - 1);
  localparam logic [CW-1:0]   LAST_COL      = CW'(COLUMNS - 1);

  logic [2:0]        state;
  logic [AW-1:0]     ptr;
  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [AW-1:0]     loc;
  cmd_t              cmd_q;
  logic              scrolled_q;
  logic [CELL_W-1:0] data_q;
  logic              mv_live;
  logic              mv_blank;
  logic [AW-1:0]     mv_addr;

  logic              is_glyph;
  logic              wrap;
  logic              do_scroll;
  logic [AW:0]       src_sum;
  logic              src_ok;
  logic [CMPW-1:0]   addr_ext;
  logic              addr_ok;
  logic [CMPW-1:0]   loc_ext;

  // cursor step decode
  assign is_glyph  = (cmd_q.character != NEWLINE_CODE);
  assign wrap      = !is_glyph || (col == LAST_COL);
  assign do_scroll = wrap && (row == LAST_ROW);

  // shared address unit: scroll source one row below, read range check
  assign src_sum  = {1'b0, ptr} + (AW + 1)'(COLUMNS);
  assign src_ok   = (src_sum < CELLS_X);
  assign addr_ext = CMPW'(cmd_q.cell_address);
  assign addr_ok  = (addr_ext < CELLS_C);

  // store port drive
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = RESET_CELL;
    rd_en   = 1'b0;
    rd_addr = src_sum[AW-1:0];
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_EXEC: begin
        if (cmd_q.mode == MODE_READ) begin
          rd_en   = 1'b1;
          rd_addr = addr_ext[AW-1:0];
        end else if (is_glyph) begin
          wr_en   = 1'b1;
          wr_addr = loc;
          wr_data = {attr, cmd_q.character};
        end
      end
      ST_SCROLL: begin
        rd_en   = src_ok;
        wr_en   = mv_live;
        wr_addr = mv_addr;
        wr_data = mv_blank ? BLANK_FILL : rd_data;
      end
      ST_DRAIN: begin
        wr_en   = mv_live;
        wr_addr = mv_addr;
        wr_data = mv_blank ? BLANK_FILL : rd_data;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      ptr     <= '0;
      row     <= '0;
      col     <= '0;
      loc     <= '0;
      mv_live <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (ptr == LAST_CELL) begin
            ptr   <= '0;
            state <= ST_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          scrolled_q <= (cmd_q.mode == MODE_PUT) && do_scroll;
          data_q     <= '0;
          if (cmd_q.mode == MODE_READ) begin
            state <= ST_READ;
          end else if (do_scroll) begin
            row   <= LAST_ROW;
            col   <= '0;
            loc   <= LAST_ROW_BASE;
            ptr   <= '0;
            state <= ST_SCROLL;
          end else if (wrap) begin
            row   <= row + 1'b1;
            col   <= '0;
            loc   <= is_glyph ? (loc + 1'b1) : (loc - AW'(col) + COL_STEP);
            state <= ST_RESP;
          end else begin
            col   <= col + 1'b1;
            loc   <= loc + 1'b1;
            state <= ST_RESP;
          end
        end
        ST_READ: begin
          data_q <= addr_ok ? rd_data : '0;
          state  <= ST_RESP;
        end
        ST_SCROLL: begin
          mv_live  <= 1'b1;
          mv_addr  <= ptr;
          mv_blank <= !src_ok;
          if (ptr == LAST_CELL) begin
            ptr   <= '0;
            state <= ST_DRAIN;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_DRAIN: begin
          mv_live <= 1'b0;
          state   <= ST_RESP;
        end
        ST_RESP: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // handshake and result
  assign loc_ext             = CMPW'(loc);
  assign cmd_ready           = (state == ST_IDLE);
  assign res_valid           = (state == ST_RESP);
  assign res.cursor_location = loc_ext[LOC_W-1:0];
  assign res.cell_data       = data_q;
  assign res.scrolled        = scrolled_q;

  // checks
  `ASSERT_ALWAYS(a_loc_in_step, clk, rst, int'(loc) == int'(row) * COLUMNS + int'(col), "cursor index out of step with row and column")
  `ASSERT_ALWAYS(a_cursor_range, clk, rst, (int'(row) < ROWS) && (int'(col) < COLUMNS), "cursor outside the screen")
  `ASSERT_IMPLY(a_scroll_cursor, clk, rst, res_valid && res.scrolled, (row == LAST_ROW) && (col == '0), "scroll left cursor off the last row start")
  `ASSERT_NEXT(a_accept_exec, clk, rst, cmd_valid && cmd_ready, state == ST_EXEC, "accepted transaction not executed")
  `ASSERT_IMPLY(a_no_idle_write, clk, rst, (state == ST_IDLE) || (state == ST_RESP), !wr_en, "store written while no item in work")

endmodule

/* design/text_console_writer.sv */
// Text console writer, top level: stream ports, attribute register, output register.
// A put item passes the sequencer states EXEC and RESP, a read item EXEC, READ and RESP;
// a put that scrolls adds SCROLL and DRAIN to copy the rows through the single store
// port pair. One item at a time: the next item is accepted once the result has left
// the sequencer. After reset a clearing pass over all ROWS*COLUMNS cells fills the
// screen before s_tready rises; uses tcw_pkg.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // character [7:0], cell_address [18:8], zero pad
  input  logic [0:0]           s_tuser,   // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // cursor_location [10:0], cell_data [26:11],
                                          // scrolled [27], zero pad
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ATTR_W-1:0]    cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [ATTR_W-1:0] attr;
  cmd_t              cmd;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  // attribute register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_valid) begin
      attr <= cfg_data;
    end
  end

  // input unpacking
  assign cmd.mode         = s_tuser[0];
  assign cmd.character    = s_tdata[CHAR_W-1:0];
  assign cmd.cell_address = s_tdata[CHAR_W+LOC_W-1:CHAR_W];

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (cmd),
    .attr      (attr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {(M_TDATA_W - $bits(res_t))'(0), res};
    end
  end

endmodule

/* test/tb_text_console_writer.sv */
// Testbench for text_console_writer: streams put and read transactions through the block
// and checks every result against a shadow screen, cursor and attribute kept in the bench.
// Depends on tcw_pkg and text_console_writer only.
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int REPORT_CAP  = 200;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;    // character [7:0], cell_address [18:8], zero pad
  logic [0:0]           s_tuser;    // mode
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;    // cursor_location [10:0], cell_data [26:11],
                                    // scrolled [27], zero pad
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [ATTR_W-1:0]    cfg_data;

  // shadow of the console state
  logic [CELL_W-1:0] shadow_screen [0:CELLS-1];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] text_attr;

  res_t pending_results [$];
  int   mismatch_count;
  int   cycle_count;
  logic stalls_on;

  text_console_writer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // console behaviour: applies one transaction to the shadow state, returns its result
  function automatic res_t console_predict(input logic mode, input logic [CHAR_W-1:0] ch,
                                           input logic [LOC_W-1:0] addr);
    res_t r;
    int   idx;
    r = '0;
    if (mode == MODE_READ) begin
      if (addr < CELLS) r.cell_data = shadow_screen[addr];
    end else begin
      if (ch == NEWLINE_CODE) begin
        cur_col = 0;
        cur_row++;
      end else begin
        idx = cur_row * COLUMNS + cur_col;
        if (idx < CELLS) shadow_screen[idx] = {text_attr, ch};
        cur_col++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col -= COLUMNS;
        cur_row++;
      end
      // scroll up one row; bottom row gets black-on-black spaces
      if (cur_row >= ROWS) begin
        for (int i = 0; i < COLUMNS * (ROWS - 1); i++)
          shadow_screen[i] = shadow_screen[i + COLUMNS];
        for (int i = COLUMNS * (ROWS - 1); i < CELLS; i++)
          shadow_screen[i] = BLANK_FILL;
        cur_row = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_location = LOC_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result checker: compares each output transaction with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[$bits(res_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.cursor_location !== want.cursor_location) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: cursor_location expected %0d actual %0d", $time,
                     want.cursor_location, got.cursor_location);
        end
        if (got.cell_data !== want.cell_data) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: cell_data expected %h actual %h", $time,
                     want.cell_data, got.cell_data);
        end
        if (got.scrolled !== want.scrolled) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: scrolled expected %0b actual %0b", $time,
                     want.scrolled, got.scrolled);
        end
      end
    end
  end

  // output back-pressure: random stall bursts with m_tready low while enabled
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // send one transaction; called at a falling edge, returns at a falling edge
  task automatic send_item(input logic mode, input logic [CHAR_W-1:0] ch,
                           input logic [LOC_W-1:0] addr);
    int gap;
    if (stalls_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - LOC_W - CHAR_W){1'b0}}, addr, ch};
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(console_predict(mode, ch, addr));
    @(negedge clk);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(MODE_PUT, ch, LOC_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [LOC_W-1:0] addr);
    send_item(MODE_READ, CHAR_W'($urandom_range(0, 255)), addr);
  endtask

  // wait until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // attribute write; only called with the block idle
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    text_attr = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // read address biased towards the bottom rows and the out-of-range tail
  function automatic logic [LOC_W-1:0] pick_read_address();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)
      return LOC_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
    else if (sel == 4)
      return LOC_W'($urandom_range(CELLS, 2047));
    else
      return LOC_W'($urandom_range(0, CELLS - 1));
  endfunction

  // screen contents straight after the clearing pass, address extremes
  task automatic test_after_reset();
    read_cell(LOC_W'(0));
    read_cell(LOC_W'(CELLS - 1));
    read_cell(LOC_W'(CELLS));
    read_cell(LOC_W'(2047));
  endtask

  // glyph extremes, carriage return as glyph, newline, attribute extremes
  task automatic test_glyphs_and_attribute();
    write_attribute(8'h00);
    put_char(8'h00);
    put_char(8'hFF);
    write_attribute(8'hFF);
    put_char(8'd13);
    put_char(8'h41);
    put_char(NEWLINE_CODE);
    put_char(8'h7E);
    for (int i = 0; i < 4; i++) read_cell(LOC_W'(i));
    read_cell(LOC_W'(COLUMNS));
    read_cell(LOC_W'(COLUMNS + 1));
  endtask

  // lines of random text with reads mixed in; wraps and scrolls come naturally
  task automatic test_random_text(input int n_items, input logic [ATTR_W-1:0] attr);
    int sent;
    int line_len;
    int sel;
    write_attribute(attr);
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)      line_len = $urandom_range(0, 20);
      else if (sel < 8) line_len = $urandom_range(21, 77);
      else if (sel < 9) line_len = $urandom_range(78, 81);
      else              line_len = $urandom_range(82, 170);
      for (int k = 0; k < line_len && sent < n_items; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          read_cell(pick_read_address());
        end else if ($urandom_range(0, 19) == 0) begin
          // noise: any byte, newline included
          put_char(CHAR_W'($urandom_range(0, 255)));
        end else begin
          sel = $urandom_range(0, 255);
          put_char(sel == NEWLINE_CODE ? CHAR_W'(13) : CHAR_W'(sel));
        end
        sent++;
      end
      if (sent < n_items) begin
        put_char(NEWLINE_CODE);
        sent++;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    stalls_on      = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = RESET_CELL;
    cur_row   = 0;
    cur_col   = 0;
    text_attr = ATTR_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_glyphs_and_attribute();
    stalls_on = 1'b1;
    test_random_text(700, ATTR_W'($urandom_range(0, 255)));
    test_random_text(700, ATTR_W'($urandom_range(0, 255)));
    stalls_on = 1'b0;
    test_random_text(400, ATTR_RESET);

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
